// ----- sv/glr_pkg.sv -----
package glr_pkg;

  // Coordinate width is fixed by the word layout
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS_DEF = 16;

  typedef struct packed {
    logic                  mode;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic [31:0]           start_argb;
    logic [31:0]           end_argb;
  } item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [31:0]           pixel_argb;
    logic                  last;
  } pixel_t;

  // Classified word handed from the front to the back
  typedef struct packed {
    logic  is_start;
    item_t item;
  } qword_t;

  typedef struct packed {
    logic   valid;
    qword_t word;
  } qout_t;

endpackage

// ----- sv/gradient_line_rasterizer_top.sv -----
// Line rasteriser with colour gradient. A start word (mode 0) latches both
// endpoints and colours and produces no pixel; it occupies the engine while
// the bit-serial divider forms the slope and the iterative square root
// forms the line length. Each step word (mode 1) yields one pixel: the end
// pixel needs no arithmetic, any other pixel one serial square root for the
// distance and, unless the line length is zero, four serial divisions, one
// per channel. Step words while no line is active are dropped. A two-word
// queue in front keeps accepting, until it holds two words, while the
// engine works and a result waits on the output.
module gradient_line_rasterizer_top #(
  parameter int FRAC_BITS = glr_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  glr_pkg::item_t  item,
  output logic            pixel_valid,
  input  logic            pixel_stall,
  output glr_pkg::pixel_t pixel
);
  import glr_pkg::*;

  qout_t qo;
  logic  pop;

  glr_front u_front (
    .clk(clk), .rst(rst), .item_valid(item_valid), .item_stall(item_stall),
    .item(item), .qo(qo), .pop(pop)
  );

  glr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .qo(qo), .pop(pop),
    .pixel_valid(pixel_valid), .pixel_stall(pixel_stall), .pixel(pixel)
  );

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> qo.valid)
    else $error("engine popped an empty queue");
  a_full_nonempty: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> qo.valid)
    else $error("queue stalls input while empty");
`endif

endmodule

// ----- sv/glr_front.sv -----
module glr_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  input  glr_pkg::item_t item,
  output glr_pkg::qout_t qo,
  input  logic          pop
);
  import glr_pkg::*;

  qword_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign item_stall = (count == 2'd2);
  assign push       = item_valid && !item_stall;

  // Classify and store incoming words
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr].is_start <= !item.mode;
      mem[wr_ptr].item     <= item;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign qo.valid = (count != 2'd0);
  assign qo.word  = mem[rd_ptr];

endmodule

// ----- sv/glr_sqrt.sv -----
module glr_sqrt #(
  parameter int FRAC_BITS = glr_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  input  logic [2*glr_pkg::COORD_BITS:0]          sq,
  output logic                                    busy,
  output logic [glr_pkg::COORD_BITS+FRAC_BITS:0]  root
);
  import glr_pkg::*;

  localparam int LW  = COORD_BITS + FRAC_BITS + 1;
  localparam int RW  = LW + 3;
  localparam int SSW = 2 * COORD_BITS + 2;
  localparam int CW  = $clog2(LW + 1);

  logic [SSW-1:0] sqs;
  logic [RW-1:0]  rem;
  logic [CW-1:0]  cnt;
  logic [RW-1:0]  rem_s;
  logic [RW-1:0]  trial;

  // One result bit per cycle, two radicand bits consumed
  assign rem_s = {rem[RW-3:0], sqs[SSW-1 -: 2]};
  assign trial = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(LW);
      sqs  <= {1'b0, sq};
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      sqs <= {sqs[SSW-3:0], 2'b00};
      if (rem_s >= trial) begin
        rem  <= rem_s - trial;
        root <= {root[LW-2:0], 1'b1};
      end else begin
        rem  <= rem_s;
        root <= {root[LW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end

endmodule

// ----- sv/glr_div.sv -----
module glr_div #(
  parameter int NW = 37,
  parameter int DW = 29
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rmd
);
  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] dreg;
  logic [CW-1:0] cnt;
  logic [DW:0]   trial;

  // Restoring division, one quotient bit per cycle
  assign trial = {rmd, quo[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(NW);
      quo  <= num;
      rmd  <= '0;
      dreg <= den;
    end else if (busy) begin
      if (trial >= {1'b0, dreg}) begin
        rmd <= DW'(trial - {1'b0, dreg});
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rmd <= trial[DW-1:0];
        quo <= {quo[NW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end

endmodule

// ----- sv/glr_back.sv -----
module glr_back #(
  parameter int FRAC_BITS = glr_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  glr_pkg::qout_t  qo,
  output logic            pop,
  output logic            pixel_valid,
  input  logic            pixel_stall,
  output glr_pkg::pixel_t pixel
);
  import glr_pkg::*;

  localparam int C    = COORD_BITS;
  localparam int PW   = C + FRAC_BITS;
  localparam int SW   = PW + 1;
  localparam int LW   = PW + 1;
  localparam int NUMW = LW + 8;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LINE  = 4'd1;
  localparam logic [3:0] S_LWAIT = 4'd2;
  localparam logic [3:0] S_SQ    = 4'd3;
  localparam logic [3:0] S_DIST  = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_DWAIT = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  localparam logic [SW-1:0] UNIT = SW'(1) << FRAC_BITS;
  localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

  logic [3:0]      state;
  logic            active;
  logic [PW-1:0]   posx, posy;
  logic [SW-1:0]   stpx, stpy;
  logic            xmaj;
  logic [C-1:0]    sx, sy, ex, ey, px, py;
  logic [31:0]     c0, c1, argb;
  logic [LW-1:0]   len, rdist;
  logic [1:0]      ch;
  logic [NUMW-1:0] mag;
  logic            neg;
  logic            last_r;

  logic [C-1:0]    adx, ady, dmaj, dmin;
  logic [2*C:0]    sq;
  logic            sq_start, sq_busy;
  logic [LW-1:0]   root;
  logic            dv_start, dv_busy;
  logic [NUMW-1:0] dv_num, quo;
  logic [LW-1:0]   dv_den, rmd;
  logic [PW-1:0]   rsum;
  logic [C-1:0]    target;
  logic [7:0]      ca, cb;
  logic [8:0]      adiff;
  logic signed [NUMW+1:0] qs, vv;
  logic [SW-1:0]   minor;
  item_t           it;
  logic            idx, idy;

  assign it = qo.word.item;
  assign idx = (it.start_x > it.end_x) ? 1'b0 : 1'b1;
  assign idy = (it.start_y > it.end_y) ? 1'b0 : 1'b1;

  // Distance terms from the start point to the current point
  assign adx  = (sx > px) ? sx - px : px - sx;
  assign ady  = (sy > py) ? sy - py : py - sy;
  assign sq   = (2*C+1)'(adx * adx) + (2*C+1)'(ady * ady);
  assign dmaj = xmaj ? adx : ady;
  assign dmin = xmaj ? ady : adx;

  // Shared divider: slope at line start, colour ratio per channel
  assign dv_num = (state == S_LINE) ? NUMW'({dmin, {FRAC_BITS{1'b0}}}) : mag;
  assign dv_den = (state == S_LINE) ? LW'(dmaj) : len;

  // End test on the major axis, rounded half up
  assign rsum   = (xmaj ? posx : posy) + HALF;
  assign target = xmaj ? ex : ey;

  assign ca    = c0[{ch, 3'b000} +: 8];
  assign cb    = c1[{ch, 3'b000} +: 8];
  assign adiff = (cb >= ca) ? {1'b0, cb} - {1'b0, ca} : {1'b0, ca} - {1'b0, cb};

  // Floor of signed quotient, then offset and clamp
  assign qs = neg ? -$signed({2'b00, quo}) - $signed((NUMW+2)'(rmd != '0))
                  : $signed({2'b00, quo});
  assign vv = qs + $signed((NUMW+2)'(ca));

  assign minor = quo[SW-1:0];

  assign pop      = (state == S_IDLE) && qo.valid;
  assign sq_start = (state == S_LINE) || (state == S_SQ);
  assign dv_start = ((state == S_LINE) && (dmaj != '0)) || (state == S_DIV);

  glr_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .sq(sq), .busy(sq_busy), .root(root)
  );

  glr_div #(.NW(NUMW), .DW(LW)) u_div (
    .clk(clk), .rst(rst), .start(dv_start), .num(dv_num), .den(dv_den),
    .busy(dv_busy), .quo(quo), .rmd(rmd)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      active      <= 1'b0;
      pixel_valid <= 1'b0;
      posx <= '0; posy <= '0; stpx <= '0; stpy <= '0; xmaj <= 1'b0;
      sx <= '0; sy <= '0; ex <= '0; ey <= '0; c0 <= '0; c1 <= '0; len <= '0;
    end else begin
      if (pixel_valid && !pixel_stall && state != S_OUT) pixel_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (qo.valid) begin
            if (qo.word.is_start) begin
              sx <= it.start_x; sy <= it.start_y;
              ex <= it.end_x;   ey <= it.end_y;
              px <= it.end_x;   py <= it.end_y;
              c0 <= it.start_argb; c1 <= it.end_argb;
              posx <= {it.start_x, {FRAC_BITS{1'b0}}};
              posy <= {it.start_y, {FRAC_BITS{1'b0}}};
              xmaj <= ((it.start_x > it.end_x) ? it.start_x - it.end_x
                                               : it.end_x - it.start_x) >
                      ((it.start_y > it.end_y) ? it.start_y - it.end_y
                                               : it.end_y - it.start_y);
              stpx <= idx ? SW'(0) : SW'(1);
              stpy <= idy ? SW'(0) : SW'(1);
              active <= 1'b1;
              state  <= S_LINE;
            end else if (active) begin
              if (rsum[PW-1:FRAC_BITS] == target) begin
                px <= ex; py <= ey; argb <= c1; last_r <= 1'b1;
                active <= 1'b0;
                state  <= S_OUT;
              end else begin
                px <= posx[PW-1:FRAC_BITS];
                py <= posy[PW-1:FRAC_BITS];
                posx <= posx + stpx[PW-1:0];
                posy <= posy + stpy[PW-1:0];
                last_r <= 1'b0;
                state  <= S_SQ;
              end
            end
          end
        end
        // Direction flags ride in stpx/stpy bit 0 until the slope is known
        S_LINE: state <= S_LWAIT;
        S_LWAIT: begin
          if (!sq_busy && !dv_busy) begin
            len <= root;
            if (dmaj == '0) begin
              stpx <= '0; stpy <= '0;
            end else if (xmaj) begin
              stpx <= stpx[0] ? -UNIT : UNIT;
              stpy <= stpy[0] ? -minor : minor;
            end else begin
              stpy <= stpy[0] ? -UNIT : UNIT;
              stpx <= stpx[0] ? -minor : minor;
            end
            state <= S_IDLE;
          end
        end
        S_SQ: state <= S_DIST;
        S_DIST: begin
          if (!sq_busy) begin
            rdist <= root;
            ch    <= 2'd3;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (len == '0) begin
            argb[{ch, 3'b000} +: 8] <= ca;
            ch    <= ch - 2'd1;
            state <= (ch == 2'd0) ? S_OUT : S_MUL;
          end else begin
            neg   <= cb < ca;
            mag   <= NUMW'(adiff[7:0] * rdist);
            state <= S_DIV;
          end
        end
        S_DIV: state <= S_DWAIT;
        S_DWAIT: begin
          if (!dv_busy) begin
            if (vv < 0)
              argb[{ch, 3'b000} +: 8] <= 8'd0;
            else if (vv > 255)
              argb[{ch, 3'b000} +: 8] <= 8'd255;
            else
              argb[{ch, 3'b000} +: 8] <= vv[7:0];
            ch    <= ch - 2'd1;
            state <= (ch == 2'd0) ? S_OUT : S_MUL;
          end
        end
        S_OUT: begin
          if (!pixel_valid || !pixel_stall) begin
            pixel_valid      <= 1'b1;
            pixel.pixel_x    <= px;
            pixel.pixel_y    <= py;
            pixel.pixel_argb <= argb;
            pixel.last       <= last_r;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sim/glr_checker.sv -----
module glr_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  logic            item_stall,
  input  glr_pkg::item_t  item,
  input  logic            pixel_valid,
  input  logic            pixel_stall,
  input  glr_pkg::pixel_t pixel,
  output int              fail_count,
  output int              pending
);
  import glr_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam longint PMASK = (64'd1 << (COORD_BITS + FB)) - 1;
  localparam longint SMASK = (64'd1 << (COORD_BITS + FB + 1)) - 1;

  // shadow line state
  bit          drawing;
  longint      px_fx, py_fx, sx_fx, sy_fx, len_fx;
  bit          x_major;
  longint      sx0, sy0, ex0, ey0;
  logic [31:0] col0, col1;
  pixel_t      pixels_due[$];

  function automatic longint unsigned root_fx(longint unsigned sq);
    longint unsigned r, rem, pr, t;
    r = 0;
    rem = 0;
    for (int p = COORD_BITS + FB; p >= 0; p--) begin
      pr = (p >= FB) ? ((sq >> (2 * (p - FB))) & 3) : 0;
      rem = (rem << 2) | pr;
      t = (r << 2) | 1;
      if (rem >= t) begin
        rem -= t;
        r = (r << 1) | 1;
      end else begin
        r = r << 1;
      end
    end
    return r;
  endfunction

  function automatic longint span(longint a, longint b);
    return a > b ? a - b : b - a;
  endfunction

  function automatic logic [31:0] shade(longint d);
    logic [31:0] o;
    longint a, b, v, num, q;
    o = 0;
    for (int sh = 24; sh >= 0; sh -= 8) begin
      a = longint'((col0 >> sh) & 32'hff);
      b = longint'((col1 >> sh) & 32'hff);
      v = a;
      if (len_fx != 0) begin
        num = (b - a) * d;
        q = num / len_fx;
        if (num % len_fx != 0 && num < 0) q--;
        v = a + q;
      end
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      o |= 32'(v[7:0]) << sh;
    end
    return o;
  endfunction

  // predict on each accepted input word
  task automatic predict_pixel(item_t w);
    longint dx, dy, mn, maj, tgt, cx, cy;
    longint unit;
    pixel_t p;
    unit = 64'd1 << FB;
    if (!w.mode) begin
      sx0 = longint'(w.start_x); sy0 = longint'(w.start_y);
      ex0 = longint'(w.end_x); ey0 = longint'(w.end_y);
      col0 = w.start_argb; col1 = w.end_argb;
      dx = span(sx0, ex0); dy = span(sy0, ey0);
      x_major = dx > dy;
      if (x_major) begin
        mn = (dy << FB) / dx;
        sx_fx = (sx0 < ex0) ? unit : (-unit & SMASK);
        sy_fx = (sy0 < ey0) ? mn : (-mn & SMASK);
      end else begin
        mn = dy != 0 ? (dx << FB) / dy : 0;
        sy_fx = dy != 0 ? ((sy0 < ey0) ? unit : (-unit & SMASK)) : 0;
        sx_fx = (sx0 < ex0) ? mn : (-mn & SMASK);
      end
      px_fx = sx0 << FB;
      py_fx = sy0 << FB;
      len_fx = root_fx(dx * dx + dy * dy);
      drawing = 1;
      return;
    end
    if (!drawing) return;
    maj = x_major ? px_fx : py_fx;
    tgt = x_major ? ex0 : ey0;
    if ((((maj + (64'd1 << (FB - 1))) >> FB) & 12'hfff) == tgt) begin
      p.pixel_x = ex0[11:0]; p.pixel_y = ey0[11:0];
      p.pixel_argb = col1; p.last = 1'b1;
      drawing = 0;
    end else begin
      cx = (px_fx >> FB) & 12'hfff;
      cy = (py_fx >> FB) & 12'hfff;
      p.pixel_x = cx[11:0]; p.pixel_y = cy[11:0]; p.last = 1'b0;
      p.pixel_argb = shade(root_fx(span(sx0, cx) ** 2 + span(sy0, cy) ** 2));
      px_fx = (px_fx + sx_fx) & PMASK;
      py_fx = (py_fx + sy_fx) & PMASK;
    end
    pixels_due.push_back(p);
  endtask

  // watch both channels, compare each pixel word with the oldest prediction
  always @(posedge clk) begin
    pixel_t e;
    if (rst) begin
      drawing = 0;
      len_fx = 0;
      fail_count = 0;
    end else begin
      if (pixel_valid && !pixel_stall) begin
        if (pixels_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected pixel %h", pixel);
        end else begin
          e = pixels_due.pop_front();
          if (e.pixel_x !== pixel.pixel_x || e.pixel_y !== pixel.pixel_y ||
              e.pixel_argb !== pixel.pixel_argb || e.last !== pixel.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"pixel mismatch: expected x=%0d y=%0d argb=%h last=%b,",
                        " got x=%0d y=%0d argb=%h last=%b"},
                       e.pixel_x, e.pixel_y, e.pixel_argb, e.last,
                       pixel.pixel_x, pixel.pixel_y, pixel.pixel_argb, pixel.last);
          end
        end
      end
      if (item_valid && !item_stall) predict_pixel(item);
    end
    pending = pixels_due.size();
  end
endmodule

// ----- sim/tb.sv -----
module tb;
  import glr_pkg::*;

  localparam int IW = $bits(item_t);

  logic   clk = 0;
  logic   rst = 1;
  logic   item_valid = 0;
  logic   item_stall;
  item_t  item = '0;
  logic   pixel_valid;
  logic   pixel_stall = 0;
  pixel_t pixel;
  int     fail_count, pending;
  int     src_idle = 0, sink_stall = 0;
  int     quiet = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  gradient_line_rasterizer_top dut (.*);
  glr_checker chk (.*);

  // stall the pixel side at random
  always @(posedge clk) pixel_stall <= ($urandom_range(99) < sink_stall);

  // watchdog: a long line of worst-case pixels under heavy stalls
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (pixel_valid && !pixel_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_word(item_t w);
    while ($urandom_range(99) < src_idle) begin
      item_valid <= 0;
      @(posedge clk);
    end
    item_valid <= 1;
    item <= w;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  task automatic start_line(int sx, int sy, int ex, int ey,
                            logic [31:0] c0, logic [31:0] c1);
    item_t w;
    w = '{1'b0, sx[11:0], sy[11:0], ex[11:0], ey[11:0], c0, c1};
    send_word(w);
  endtask

  task automatic step_pixel();
    item_t w;
    w = IW'({$urandom, $urandom, $urandom, $urandom});
    w.mode = 1;
    send_word(w);
  endtask

  initial begin
    int n, len;
    repeat (4) @(posedge clk);
    rst <= 0;
    // directed: idle step, degenerate, ties, extremes, restart mid-line
    step_pixel();
    start_line(5, 5, 5, 5, 32'h12345678, 32'h9abcdef0);
    repeat (2) step_pixel();
    start_line(0, 0, 4095, 4095, 32'h00000000, 32'hffffffff);
    repeat (3) step_pixel();
    start_line(4095, 0, 0, 2, 32'hffffffff, 32'h00000000);
    repeat (2) step_pixel();
    start_line(10, 20, 13, 20, 32'hff00ff00, 32'h00ff00ff);
    repeat (5) step_pixel();
    start_line(7, 4095, 9, 4091, 32'h80808080, 32'h7f7f7f7f);
    repeat (6) step_pixel();
    n = 0;
    for (int ph = 0; ph < 4; ph++) begin
      src_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 68 : 29) : 0;
      sink_stall = (ph == 2) ? 68 : (ph == 3 ? 29 : 0);
      while (n < 200 * (ph + 1)) begin
        int sx, sy, ex, ey;
        sx = $urandom_range(4095);
        sy = $urandom_range(4095);
        len = $urandom_range(99) < 3 ? 4095 : $urandom_range(10);
        ex = $urandom_range(99) < 10 ? $urandom_range(4095)
                                     : (sx + $urandom_range(2 * len) - len) & 4095;
        ey = (sy + $urandom_range(2 * len) - len) & 4095;
        start_line(sx, sy, ex, ey, $urandom, $urandom);
        n++;
        len = $urandom_range(99) < 80 ? 14 : $urandom_range(3);
        repeat ($urandom_range(len)) begin
          step_pixel();
          n++;
        end
      end
    end
    item_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
